>>> hdl/integer_text_parser_macros.svh
// Assertion macros for the integer text parser checker.
// Both take the clock and the active-low reset from the scope that uses them.
`ifndef INTEGER_TEXT_PARSER_MACROS_SVH
`define INTEGER_TEXT_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ITP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("integer_text_parser: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define ITP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("integer_text_parser: next-cycle check failed");

`endif

>>> hdl/itp_pkg.sv
// Shared types and constants for the integer text parser.
// No dependencies; used by every design module of the block.
package itp_pkg;

    localparam int VALUE_BITS = 32;
    localparam int OUT_VALUE_BITS = 32;
    localparam int RADIX_BITS = 6;
    localparam int COUNT_BITS = 16;
    localparam int CHAR_BITS = 8;
    localparam int DIGIT_BITS = 7;

    localparam logic [RADIX_BITS-1:0] RADIX_MAX = RADIX_BITS'(36);
    localparam logic [RADIX_BITS-1:0] RADIX_AUTO = RADIX_BITS'(0);
    localparam logic [RADIX_BITS-1:0] RADIX_OCT = RADIX_BITS'(8);
    localparam logic [RADIX_BITS-1:0] RADIX_DEC = RADIX_BITS'(10);
    localparam logic [RADIX_BITS-1:0] RADIX_HEX = RADIX_BITS'(16);
    localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_DEC;

    // Configuration register indexes
    localparam logic CFG_RADIX = 1'b0;
    localparam logic CFG_SIGNED = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD1,
        PH_LEAD2,
        PH_START,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } itp_phase_t;

    typedef struct packed {
        logic [RADIX_BITS-1:0] radix;
        logic                  signed_mode;
    } itp_cfg_t;

    typedef struct packed {
        itp_phase_t            phase;
        logic [RADIX_BITS-1:0] active_radix;
        logic                  is_negative;
        logic [VALUE_BITS-1:0] accumulator;
        logic [COUNT_BITS-1:0] char_count;
        logic                  saw_digit;
    } itp_state_t;

    typedef struct packed {
        logic [OUT_VALUE_BITS-1:0] value;
        logic [COUNT_BITS-1:0]     consumed;
        logic                      digits_found;
    } itp_result_t;

    typedef struct packed {
        logic [CHAR_BITS-1:0] ch;
        logic                 first;
        logic                 final_req;
    } itp_item_t;

endpackage

>>> hdl/itp_in_stage.sv
// Input register of the integer text parser: holds one character transaction.
// Depends on itp_pkg for the item type.
module itp_in_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  itp_pkg::itp_item_t in_item,
    output logic               held_valid,
    output itp_pkg::itp_item_t held_item,
    input  logic               advance
);

    logic               valid_reg;
    logic               valid_next;
    itp_pkg::itp_item_t item_reg;

    // Take a new transaction whenever the held one is empty or moves on.
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_valid ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

>>> hdl/itp_step.sv
// Per-character parse step: next parse state and an optional result.
// Depends on itp_pkg for the state, configuration and result types.
module itp_step
(
    input  itp_pkg::itp_item_t   item,
    input  itp_pkg::itp_cfg_t    cfg,
    input  itp_pkg::itp_state_t  state,
    output itp_pkg::itp_state_t  state_next,
    output logic                 emit,
    output itp_pkg::itp_result_t result
);

    function automatic logic [itp_pkg::DIGIT_BITS-1:0] digit_of(
        input logic [itp_pkg::CHAR_BITS-1:0] c
    );
        logic [itp_pkg::DIGIT_BITS-1:0] d;
        begin
            if (c >= "0" && c <= "9")
                d = itp_pkg::DIGIT_BITS'(c - "0");
            else if (c >= "a" && c <= "z")
                d = itp_pkg::DIGIT_BITS'(c - "a" + 8'd10);
            else if (c >= "A" && c <= "Z")
                d = itp_pkg::DIGIT_BITS'(c - "A" + 8'd10);
            else
                d = '1;
            return d;
        end
    endfunction

    always_comb
    begin
        itp_pkg::itp_state_t            s;
        logic                           blank;
        logic                           done;
        logic                           took;
        logic                           fire;
        logic [itp_pkg::DIGIT_BITS-1:0] d;
        logic [itp_pkg::VALUE_BITS-1:0] prod;
        logic [itp_pkg::VALUE_BITS-1:0] v;

        s     = state;
        blank = (item.ch == " ") || (item.ch == 8'h09);
        done  = 1'b0;
        took  = 1'b0;
        fire  = 1'b0;
        d     = digit_of(item.ch);
        prod  = '0;

        // A new string clears the state and samples the configuration.
        if (item.first)
        begin
            s.phase        = cfg.signed_mode ? itp_pkg::PH_LEAD1 : itp_pkg::PH_LEAD2;
            s.active_radix = (cfg.radix > itp_pkg::RADIX_MAX) ? itp_pkg::RADIX_MAX
                                                              : cfg.radix;
            s.is_negative  = 1'b0;
            s.accumulator  = '0;
            s.char_count   = '0;
            s.saw_digit    = 1'b0;
        end

        if (s.phase == itp_pkg::PH_IDLE || s.phase == itp_pkg::PH_DONE)
        begin
            done = 1'b1;
        end
        else
        begin
            // The phases only move forward, so one pass in order covers them.
            if (s.phase == itp_pkg::PH_LEAD1 && !done)
            begin
                if (blank)
                begin
                    took = 1'b1; done = 1'b1;
                end
                else
                begin
                    s.phase = itp_pkg::PH_LEAD2;
                    if (item.ch == "-")
                    begin
                        s.is_negative = 1'b1; took = 1'b1; done = 1'b1;
                    end
                    else if (item.ch == "+")
                    begin
                        took = 1'b1; done = 1'b1;
                    end
                end
            end
            if (s.phase == itp_pkg::PH_LEAD2 && !done)
            begin
                if (blank)
                begin
                    took = 1'b1; done = 1'b1;
                end
                else
                begin
                    s.phase = itp_pkg::PH_START;
                    if (item.ch == "+")
                    begin
                        took = 1'b1; done = 1'b1;
                    end
                end
            end
            if (s.phase == itp_pkg::PH_START && !done)
            begin
                if (s.active_radix == itp_pkg::RADIX_AUTO)
                begin
                    if (item.ch == "0")
                    begin
                        s.active_radix = itp_pkg::RADIX_OCT;
                        s.saw_digit    = 1'b1;
                        s.phase        = itp_pkg::PH_ZERO;
                        took = 1'b1; done = 1'b1;
                    end
                    else
                    begin
                        s.active_radix = itp_pkg::RADIX_DEC;
                        s.phase        = itp_pkg::PH_DIGITS;
                    end
                end
                else if (s.active_radix == itp_pkg::RADIX_HEX && item.ch == "0")
                begin
                    s.saw_digit = 1'b1;
                    s.phase     = itp_pkg::PH_ZERO;
                    took = 1'b1; done = 1'b1;
                end
                else
                begin
                    s.phase = itp_pkg::PH_DIGITS;
                end
            end
            if (s.phase == itp_pkg::PH_ZERO && !done)
            begin
                s.phase = itp_pkg::PH_DIGITS;
                if (item.ch == "x" || item.ch == "X")
                begin
                    s.active_radix = itp_pkg::RADIX_HEX;
                    s.saw_digit    = 1'b0;
                    took = 1'b1; done = 1'b1;
                end
            end
            if (s.phase == itp_pkg::PH_DIGITS && !done)
            begin
                done = 1'b1;
                if (d < {1'b0, s.active_radix})
                begin
                    prod          = s.accumulator * itp_pkg::VALUE_BITS'(s.active_radix);
                    s.accumulator = prod + itp_pkg::VALUE_BITS'(d);
                    s.saw_digit   = 1'b1;
                    took          = 1'b1;
                end
            end

            // A rejected character ends the string uncounted.
            if (!took)
            begin
                fire = 1'b1;
            end
            else
            begin
                if (s.char_count != '1)
                    s.char_count = s.char_count + 1'b1;
                fire = item.final_req;
            end
            if (fire)
                s.phase = itp_pkg::PH_DONE;
        end

        v = s.is_negative ? (~s.accumulator + 1'b1) : s.accumulator;

        state_next          = s;
        emit                = fire;
        result.value        = itp_pkg::OUT_VALUE_BITS'(v);
        result.consumed     = s.char_count;
        result.digits_found = s.saw_digit;
    end

endmodule

>>> hdl/itp_out_stage.sv
// Result register of the integer text parser with its valid flag.
// Depends on itp_pkg for the result type.
module itp_out_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  itp_pkg::itp_result_t load_result,
    output logic                 out_valid,
    input  logic                 out_ready,
    output itp_pkg::itp_result_t out_result,
    output logic                 can_load
);

    logic                 valid_reg;
    logic                 valid_next;
    itp_pkg::itp_result_t result_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

>>> hdl/integer_text_parser.sv
// Streaming text-to-integer parser (strtol / strtoul style), top level.
// Depends on itp_pkg, itp_in_stage, itp_step and itp_out_stage.
//
// Usage:
//   Characters arrive on the slave stream, one per transaction: tdata[7:0]
//   is the character, tuser marks the first character of a string and tlast
//   asks for a result after that character. Each string gives one result on
//   the master stream when it ends, either at a character that cannot
//   continue the number or at tlast; characters after that are dropped
//   until the next string start. Configuration (radix, signed mode) is
//   written on cfg_we/cfg_index/cfg_data and sampled at each string start;
//   the user must write it only while the block is idle (not enforced). The
//   character that ends a string is held in the input register and its
//   result in the result register. Throughput: one character per cycle
//   while the result register has room, set by the single multiply-add of
//   the accumulator by the radix between the input and result registers.
//   Stall: when the result register is full and m_tready is low, hold the
//   held character and drop s_tready once one is held; otherwise characters
//   keep flowing. Reset: both stream registers empty, radix 10, signed mode
//   on, no string open until a transaction with tuser set arrives.
module integer_text_parser
(
    input  logic        clk,
    input  logic        rst_n,
    // character stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tuser,   // [0] first
    input  logic        s_tlast,   // final_req
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] value, [47:32] consumed
    output logic        m_tuser,   // [0] digits_found
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [5:0]  cfg_data
);

    itp_pkg::itp_cfg_t    cfg_reg;
    itp_pkg::itp_cfg_t    cfg_next;
    itp_pkg::itp_state_t  state_reg;
    itp_pkg::itp_state_t  state_next;
    itp_pkg::itp_item_t   in_item;
    itp_pkg::itp_item_t   held_item;
    itp_pkg::itp_result_t step_result;
    itp_pkg::itp_result_t out_result;
    logic                 held_valid;
    logic                 advance;
    logic                 can_load;
    logic                 step_emit;

    assign in_item.ch        = s_tdata;
    assign in_item.first     = s_tuser;
    assign in_item.final_req = s_tlast;

    // Configuration registers, written by index.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                itp_pkg::CFG_RADIX:  cfg_next.radix       = cfg_data;
                itp_pkg::CFG_SIGNED: cfg_next.signed_mode = cfg_data[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radix       <= itp_pkg::RADIX_RESET;
            cfg_reg.signed_mode <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Advance the held character whenever the result register has room.
    assign advance = held_valid && can_load;

    itp_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .held_valid (held_valid),
        .held_item  (held_item),
        .advance    (advance)
    );

    itp_step u_step
    (
        .item       (held_item),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .emit       (step_emit),
        .result     (step_result)
    );

    // Parse state moves only when the held character is consumed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase        <= itp_pkg::PH_IDLE;
            state_reg.active_radix <= '0;
            state_reg.is_negative  <= 1'b0;
            state_reg.accumulator  <= '0;
            state_reg.char_count   <= '0;
            state_reg.saw_digit    <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    itp_out_stage u_out
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance && step_emit),
        .load_result (step_result),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (out_result),
        .can_load    (can_load)
    );

    assign m_tdata = {out_result.consumed, out_result.value};
    assign m_tuser = out_result.digits_found;

endmodule

>>> hdl/itp_checker.sv
// Port-level checks for the integer text parser, bound to the top level.
// Depends on integer_text_parser_macros.svh.
`include "integer_text_parser_macros.svh"

module itp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tuser,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser,
    input logic        cfg_we,
    input logic        cfg_index,
    input logic [5:0]  cfg_data
);

    // A stalled result holds its payload.
    `ITP_ASSERT_NEXT(a_result_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // No digit means the accumulator never moved off zero.
    `ITP_ASSERT_NOW(a_no_digit_zero, m_tvalid && !m_tuser, m_tdata[31:0] == 32'd0)

    // A digit is always a counted character.
    `ITP_ASSERT_NOW(a_digit_counted, m_tvalid && m_tuser, m_tdata[47:32] != 16'd0)

    // Input back-pressure only comes from a stalled result.
    `ITP_ASSERT_NOW(a_ready_cause, !s_tready, m_tvalid && !m_tready)

endmodule

bind integer_text_parser itp_checker u_itp_checker (.*);
